// File: rtl/psc_pkg.sv
package psc_pkg;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } in_word_t;

  typedef struct packed {
    logic signed [26:0] pressure_q8_pa;
    logic signed [15:0] temp_centi_c;
    logic               saturated;
  } out_word_t;

  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
    logic [29:0] qx_shifts;
  } cal_t;

  typedef enum logic [2:0] {
    REG_C1,
    REG_C2,
    REG_C3,
    REG_C4,
    REG_C5,
    REG_C6,
    REG_QX
  } reg_idx_t;

  localparam int TEMP_BASE = 2000;
  localparam logic [23:0] PA_PER_CPSI_Q24 = 24'd11567483;
  localparam logic signed [71:0] P_CLAMP = 72'sd68719476736;
  localparam logic signed [65:0] TEMP_MAX = 66'sd32767;
  localparam logic signed [65:0] TEMP_MIN = -66'sd32768;
  localparam logic signed [61:0] PQ8_MAX = 62'sd67108863;
  localparam logic signed [61:0] PQ8_MIN = -62'sd67108864;
  localparam logic signed [61:0] ROUND_HALF = 62'sd32768;

endpackage

// File: rtl/pressure_sensor_compensation_unit.sv
// Throughput: one word per cycle; busy is never raised, so start may stay high.
// Nine register stages in the datapath; the receiver cannot stall, so nothing holds.
// Reset (rst_n low, synchronous): clears the stage valid bits and all calibration
// registers to zero; data registers are not reset.
module pressure_sensor_compensation_unit (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  psc_pkg::in_word_t  in_data,
  // result channel
  output logic               out_valid,
  output psc_pkg::out_word_t out_data,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import psc_pkg::*;

  cal_t     cal_r, cal_nxt;
  reg_idx_t reg_idx;
  logic     wr_en;

  // The pipeline never fills up: take a word in every cycle.
  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Register i sits at byte address 4*i; drop the byte offset.
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;

  // Write decode: update only the addressed word, ignore unused addresses.
  always_comb begin
    cal_nxt = cal_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_C1:  cal_nxt.c1        = pwdata[15:0];
        REG_C2:  cal_nxt.c2        = pwdata[15:0];
        REG_C3:  cal_nxt.c3        = pwdata[15:0];
        REG_C4:  cal_nxt.c4        = pwdata[15:0];
        REG_C5:  cal_nxt.c5        = pwdata[15:0];
        REG_C6:  cal_nxt.c6        = pwdata[15:0];
        REG_QX:  cal_nxt.qx_shifts = pwdata[29:0];
        default: cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  // Read back: zero-extend the addressed register.
  always_comb begin
    unique case (reg_idx)
      REG_C1:  prdata = {16'd0, cal_r.c1};
      REG_C2:  prdata = {16'd0, cal_r.c2};
      REG_C3:  prdata = {16'd0, cal_r.c3};
      REG_C4:  prdata = {16'd0, cal_r.c4};
      REG_C5:  prdata = {16'd0, cal_r.c5};
      REG_C6:  prdata = {16'd0, cal_r.c6};
      REG_QX:  prdata = {2'd0, cal_r.qx_shifts};
      default: prdata = '0;
    endcase
  end

  // Compensation pipeline: dT, coefficient products, offset and
  // sensitivity, D1*SENS, pressure in 0.0001 psi, pascal scaling, clip.
  psc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_data   (in_data),
    .cal       (cal_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: rtl/psc_datapath.sv
module psc_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  psc_pkg::in_word_t  in_data,
  input  psc_pkg::cal_t      cal,
  output logic               out_valid,
  output psc_pkg::out_word_t out_data
);
  import psc_pkg::*;

  localparam int NSTAGE = 9;

  logic [NSTAGE-1:0] v_r;

  logic [4:0] q1, q2, q3, q4, q5, q6;
  assign q1 = cal.qx_shifts[4:0];
  assign q2 = cal.qx_shifts[9:5];
  assign q3 = cal.qx_shifts[14:10];
  assign q4 = cal.qx_shifts[19:15];
  assign q5 = cal.qx_shifts[24:20];
  assign q6 = cal.qx_shifts[29:25];

  // stage 1: dT
  logic [46:0]        c5_sh;
  logic signed [48:0] dt_nxt, dt_r;
  logic [23:0]        d1_s1_r;
  assign c5_sh  = {31'd0, cal.c5} << q5;
  assign dt_nxt = $signed({25'd0, in_data.raw_temperature}) - $signed({2'd0, c5_sh});

  // stage 2: three coefficient products
  logic signed [65:0] mt_nxt, mo_nxt, ms_nxt, mt_r, mo_r, ms_r;
  logic [23:0]        d1_s2_r;
  assign mt_nxt = dt_r * $signed({1'b0, cal.c6});
  assign mo_nxt = dt_r * $signed({1'b0, cal.c4});
  assign ms_nxt = dt_r * $signed({1'b0, cal.c3});

  // stage 3: shift and add
  logic [46:0]        c1_sh, c2_sh;
  logic signed [65:0] temp_nxt, off_nxt, sens_nxt, temp_r, off_s3_r, sens_r;
  logic [23:0]        d1_s3_r;
  assign c1_sh    = {31'd0, cal.c1} << q1;
  assign c2_sh    = {31'd0, cal.c2} << q2;
  assign temp_nxt = (mt_r >>> q6) + 66'(TEMP_BASE);
  assign off_nxt  = $signed({19'd0, c2_sh}) + (mo_r >>> q4);
  assign sens_nxt = $signed({19'd0, c1_sh}) + (ms_r >>> q3);

  // stage 4: D1*SENS as two partial products, clip temperature
  logic [55:0]        pl_nxt, pl_r;
  logic signed [58:0] ph_nxt, ph_r;
  logic signed [15:0] t16_nxt, t16_s4_r;
  logic               tsat_nxt, tsat_s4_r;
  logic signed [65:0] off_s4_r;
  assign pl_nxt = d1_s3_r * sens_r[31:0];
  assign ph_nxt = $signed({1'b0, d1_s3_r}) * $signed(sens_r[65:32]);

  always_comb begin
    tsat_nxt = 1'b0;
    t16_nxt  = temp_r[15:0];
    if (temp_r > TEMP_MAX) begin
      t16_nxt  = TEMP_MAX[15:0];
      tsat_nxt = 1'b1;
    end else if (temp_r < TEMP_MIN) begin
      t16_nxt  = TEMP_MIN[15:0];
      tsat_nxt = 1'b1;
    end
  end

  // stage 5: combine partial products
  logic signed [91:0] prod_nxt, prod_r;
  logic signed [65:0] off_s5_r;
  logic signed [15:0] t16_s5_r;
  logic               tsat_s5_r;
  assign prod_nxt = ({{33{ph_r[58]}}, ph_r} <<< 32) + $signed({36'd0, pl_r});

  // stage 6: floor(D1*SENS/2^21) - OFF
  logic signed [91:0] diff_full;
  logic signed [71:0] diff_r;
  logic signed [15:0] t16_s6_r;
  logic               tsat_s6_r;
  assign diff_full = (prod_r >>> 21) - $signed({{26{off_s5_r[65]}}, off_s5_r});

  // stage 7: /2^15 and clamp
  logic signed [71:0] p_full;
  logic signed [37:0] p_nxt, p_r;
  logic signed [15:0] t16_s7_r;
  logic               tsat_s7_r;
  assign p_full = diff_r >>> 15;

  always_comb begin
    p_nxt = p_full[37:0];
    if (p_full > P_CLAMP) begin
      p_nxt = P_CLAMP[37:0];
    end else if (p_full < -P_CLAMP) begin
      p_nxt = -P_CLAMP[37:0];
    end
  end

  // stage 8: scale to pascals, split product
  logic [43:0]        sl_nxt, sl_r;
  logic signed [42:0] sh_nxt, sh_r;
  logic signed [15:0] t16_s8_r;
  logic               tsat_s8_r;
  assign sl_nxt = p_r[19:0] * PA_PER_CPSI_Q24;
  assign sh_nxt = $signed(p_r[37:20]) * $signed({1'b0, PA_PER_CPSI_Q24});

  // stage 9: round half up, clip pressure
  logic signed [61:0] sum, qv;
  out_word_t          out_nxt, out_r;
  assign sum = ({{19{sh_r[42]}}, sh_r} <<< 20) + $signed({18'd0, sl_r}) + ROUND_HALF;
  assign qv  = sum >>> 16;

  always_comb begin
    out_nxt.temp_centi_c   = t16_s8_r;
    out_nxt.pressure_q8_pa = qv[26:0];
    out_nxt.saturated      = tsat_s8_r;
    if (qv > PQ8_MAX) begin
      out_nxt.pressure_q8_pa = PQ8_MAX[26:0];
      out_nxt.saturated      = 1'b1;
    end else if (qv < PQ8_MIN) begin
      out_nxt.pressure_q8_pa = PQ8_MIN[26:0];
      out_nxt.saturated      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NSTAGE-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    dt_r      <= dt_nxt;
    d1_s1_r   <= in_data.raw_pressure;
    mt_r      <= mt_nxt;
    mo_r      <= mo_nxt;
    ms_r      <= ms_nxt;
    d1_s2_r   <= d1_s1_r;
    temp_r    <= temp_nxt;
    off_s3_r  <= off_nxt;
    sens_r    <= sens_nxt;
    d1_s3_r   <= d1_s2_r;
    pl_r      <= pl_nxt;
    ph_r      <= ph_nxt;
    off_s4_r  <= off_s3_r;
    t16_s4_r  <= t16_nxt;
    tsat_s4_r <= tsat_nxt;
    prod_r    <= prod_nxt;
    off_s5_r  <= off_s4_r;
    t16_s5_r  <= t16_s4_r;
    tsat_s5_r <= tsat_s4_r;
    diff_r    <= diff_full[71:0];
    t16_s6_r  <= t16_s5_r;
    tsat_s6_r <= tsat_s5_r;
    p_r       <= p_nxt;
    t16_s7_r  <= t16_s6_r;
    tsat_s7_r <= tsat_s6_r;
    sl_r      <= sl_nxt;
    sh_r      <= sh_nxt;
    t16_s8_r  <= t16_s7_r;
    tsat_s8_r <= tsat_s7_r;
    out_r     <= out_nxt;
  end

  assign out_valid = v_r[NSTAGE-1];
  assign out_data  = out_r;

endmodule
